@@ src/ocn_pkg.sv @@
// Package for the overload clip distortion block: register indexes, constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ocn_pkg;
	localparam int unsigned SAMPLE_W = 24;
	localparam logic [31:0] GOLDEN = 32'h9E37_79B9;
	localparam logic [30:0] ONE30 = 31'h4000_0000;
	localparam logic [30:0] COS_A = 31'd1324675879;
	localparam logic [30:0] COS_B = 31'd272375560;
	localparam logic [30:0] COS_C = 31'd22401992;
	localparam logic [30:0] COS_D = 31'd987049;

	typedef enum logic [2:0] {
		REG_CLIP_LEVEL = 3'd0,
		REG_DEPTH      = 3'd1,
		REG_PHASE_INC  = 3'd2,
		REG_NOISE_EN   = 3'd3,
		REG_COSINE_EN  = 3'd4,
		REG_MODE_COUNT = 3'd5
	} reg_index_t;

	// classified request passed from the front part to the back part
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       pos;
		logic                       neg;
		logic                       bypass;
		logic                       noise_on;
		logic                       cos_on;
		logic [31:0]                noise;   // advanced noise state
		logic [31:0]                phase;   // advanced phase
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOISE_MUL,
		ST_COS_U,
		ST_COS_D,
		ST_COS_C,
		ST_COS_B,
		ST_COS_A,
		ST_COS_M,
		ST_DIV_SETUP,
		ST_RATIO_DIV,
		ST_SUM,
		ST_CNT_DIV,
		ST_DONE
	} back_state_t;
endpackage
`default_nettype wire

@@ src/ocn_front.sv @@
// Front part: accepts requests, compares against the clip level, advances per-channel
// noise and phase state, and pushes classified jobs into a two-entry queue. Uses ocn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ocn_front #(
	parameter int unsigned CHANNELS = 2,
	parameter int unsigned CH_W = 1
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  signed [ocn_pkg::SAMPLE_W-1:0] sample_in,
	input  wire  [0:0]                      channel,
	input  wire  [22:0]                     clip_level,
	input  wire  [31:0]                     phase_increment,
	input  wire                             noise_enable,
	input  wire                             cosine_enable,
	input  wire                             job_take,
	output logic                            job_valid,
	output ocn_pkg::job_t                   job
);
	import ocn_pkg::*;

	logic [31:0] noise_q [CHANNELS];
	logic [31:0] phase_q [CHANNELS];
	job_t        fifo_q [2];
	logic        rd_ptr_q, wr_ptr_q;
	logic [1:0]  count_q;
	logic [CH_W-1:0] ch;
	logic        accept;
	logic signed [SAMPLE_W:0] s_ext, clip_ext;
	logic        pos, neg;
	logic [31:0] x1, x2, x3, nxt_noise, nxt_phase;
	job_t        new_job;

	assign full      = count_q == 2'd2;
	assign accept    = push && !full;
	assign job_valid = count_q != 2'd0;
	assign job       = fifo_q[rd_ptr_q];

	// clamp channel into range
	always_comb begin
		if (CH_W'(channel) >= CH_W'(CHANNELS - 1) && CHANNELS > 1) begin
			ch = CH_W'(CHANNELS - 1);
		end else if (CHANNELS == 1) begin
			ch = '0;
		end else begin
			ch = CH_W'(channel);
		end
	end

	// classify and advance state
	always_comb begin
		s_ext     = {sample_in[SAMPLE_W-1], sample_in};
		clip_ext  = {2'b00, clip_level};
		pos       = s_ext >= clip_ext;
		neg       = !pos && (s_ext <= -clip_ext);
		x1        = noise_q[ch] ^ (noise_q[ch] << 13);
		x2        = x1 ^ (x1 >> 17);
		x3        = x2 ^ (x2 << 5);
		nxt_noise = (x3 == 32'd0) ? GOLDEN : x3;
		nxt_phase = phase_q[ch] + phase_increment;
		new_job.sample   = sample_in;
		new_job.pos      = pos;
		new_job.neg      = neg;
		new_job.bypass   = !noise_enable && !cosine_enable;
		new_job.noise_on = noise_enable;
		new_job.cos_on   = cosine_enable;
		new_job.noise    = nxt_noise;
		new_job.phase    = nxt_phase;
	end

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				noise_q[k] <= GOLDEN * 32'(k + 3);
				phase_q[k] <= '0;
			end
		end else if (accept) begin
			if (noise_enable && (pos || neg)) begin
				noise_q[ch] <= nxt_noise;
			end
			if (cosine_enable) begin
				phase_q[ch] <= nxt_phase;
			end
		end
	end

	// job queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= new_job;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(job_take);
		end
	end
endmodule
`default_nettype wire

@@ src/ocn_back.sv @@
// Back part: works one job at a time with a shared multiplier and two serial dividers,
// then holds the result in an output register. Uses ocn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ocn_back (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             job_valid,
	input  ocn_pkg::job_t                   job,
	output logic                            job_take,
	input  wire  [22:0]                     clip_level,
	input  wire  [16:0]                     depth,
	input  wire  [3:0]                      active_mode_count,
	output logic                            empty,
	input  wire                             pop,
	output logic signed [ocn_pkg::SAMPLE_W-1:0] sample_out,
	output logic                            clipped
);
	import ocn_pkg::*;

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [16:0] dep;
	logic [30:0] u_q, q_q, x_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic signed [26:0] acc_q;
	logic signed [24:0] fn_q, fc_q;
	logic [46:0] rem_q;
	logic [46:0] quo_q;
	logic [5:0]  cnt_q;
	logic [23:0] div_d_q;
	logic [23:0] mag;
	logic        neg_res_q;
	logic        out_full_q;
	logic [47:0] trial;
	logic [30:0] cv;
	logic [30:0] t30;
	logic signed [26:0] ratio_s, res_s;
	logic        clip_any;
	logic [3:0]  nmodes;

	assign dep      = (depth > 17'd65536) ? 17'd65536 : depth;
	assign clip_any = job_q.pos || job_q.neg;
	assign nmodes   = (active_mode_count == 4'd0) ? 4'd1 : active_mode_count;
	assign empty    = !out_full_q;
	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign mag      = job_q.sample[SAMPLE_W-1] ? 24'(-job_q.sample) : 24'(job_q.sample);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_NOISE_MUL: begin mul_a = {8'd0, job_q.noise[31:8]}; mul_b = 32'(dep); end
			ST_COS_U:     begin mul_a = 32'(x_q); mul_b = 32'(x_q); end
			ST_COS_D:     begin mul_a = 32'(COS_D); mul_b = 32'(u_q); end
			ST_COS_C, ST_COS_B, ST_COS_A: begin mul_a = 32'(q_q); mul_b = 32'(u_q); end
			ST_DIV_SETUP: begin mul_a = 32'(dep); mul_b = 32'(q_q); end
			default:      begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod  = mul_a * mul_b;
	assign t30   = 31'(prod >> 30);
	assign trial = {rem_q, 1'b0} - {24'd0, div_d_q};
	assign ratio_s = job_q.sample[SAMPLE_W-1] ? -$signed({3'd0, quo_q[23:0]})
	                 : $signed({3'd0, quo_q[23:0]});

	// cosine value for quadrant correction, from the clamped result of the A step held in q_q
	assign cv = q_q;

	// sum of the enabled mode results
	always_comb begin
		res_s = '0;
		if (job_q.noise_on) begin
			res_s = res_s + (clip_any ? (job_q.pos ? 27'(fn_q) : -27'(fn_q)) : ratio_s);
		end
		if (job_q.cos_on) begin
			res_s = res_s + (clip_any ? (job_q.pos ? 27'(fc_q) : -27'(fc_q)) : ratio_s);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (job_valid) state_d = ST_NOISE_MUL;
			ST_NOISE_MUL: state_d = ST_COS_U;
			ST_COS_U:     state_d = ST_COS_D;
			ST_COS_D:     state_d = ST_COS_C;
			ST_COS_C:     state_d = ST_COS_B;
			ST_COS_B:     state_d = ST_COS_A;
			ST_COS_A:     state_d = ST_COS_M;
			ST_COS_M:     state_d = ST_DIV_SETUP;
			ST_DIV_SETUP: state_d = (clip_any || job_q.bypass) ? ST_SUM : ST_RATIO_DIV;
			ST_RATIO_DIV: if (cnt_q == 6'd1) state_d = ST_SUM;
			ST_SUM:       state_d = ST_CNT_DIV;
			ST_CNT_DIV:   if (cnt_q == 6'd1) state_d = ST_DONE;
			ST_DONE:      if (!out_full_q) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath steps
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				x_q   <= (job.phase[30] == 1'b0) ? {1'b0, job.phase[29:0]}
				         : ONE30 - {1'b0, job.phase[29:0]};
				acc_q <= '0;
			end
			ST_NOISE_MUL: fn_q <= 25'sd8388608 - $signed({1'b0, prod[40:17]});
			ST_COS_U:     u_q <= t30;
			ST_COS_D:     q_q <= COS_C - t30;
			ST_COS_C:     q_q <= COS_B - t30;
			ST_COS_B:     q_q <= COS_A - t30;
			ST_COS_A: begin
				q_q <= (t30 >= ONE30) ? 31'd0 : ONE30 - t30;
			end
			ST_COS_M: begin
				// form m here; it is multiplied by depth in the setup step
				if (job_q.phase[31] == job_q.phase[30]) begin
					q_q <= (ONE30 - cv) >> 1;
				end else begin
					q_q <= 31'(({1'b0, ONE30} + {1'b0, cv}) >> 1);
				end
				cnt_q <= 6'd1;
			end
			ST_DIV_SETUP: begin
				if (cnt_q == 6'd1) begin
					fc_q <= 25'sd8388608 - $signed({1'b0, prod[46:23]});
				end
				rem_q   <= {23'd0, mag};
				quo_q   <= '0;
				div_d_q <= {1'b0, clip_level};
				cnt_q   <= (clip_any || job_q.bypass) ? 6'd0 : 6'd23;
			end
			ST_RATIO_DIV: begin
				// restoring division of mag<<23 by clip level, one bit per cycle
				if (!trial[47]) begin
					rem_q <= trial[46:0];
					quo_q <= {quo_q[45:0], 1'b1};
				end else begin
					rem_q <= {rem_q[45:0], 1'b0};
					quo_q <= {quo_q[45:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			ST_SUM: begin
				neg_res_q <= res_s[26];
				rem_q     <= '0;
				quo_q     <= {20'd0, (res_s[26] ? 27'(-res_s) : res_s)};
				div_d_q   <= 24'(nmodes);
				cnt_q     <= 6'd27;
			end
			ST_CNT_DIV: begin
				// restoring division of the sum magnitude by the mode count
				if ({rem_q[22:0], quo_q[26]} >= div_d_q) begin
					rem_q <= 47'({rem_q[22:0], quo_q[26]} - div_d_q);
					quo_q <= {20'd0, quo_q[25:0], 1'b1};
				end else begin
					rem_q <= 47'({rem_q[22:0], quo_q[26]});
					quo_q <= {20'd0, quo_q[25:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && !out_full_q) begin
				out_full_q <= 1'b1;
			end else if (pop && out_full_q) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_full_q) begin
			clipped <= clip_any;
			if (job_q.bypass) begin
				sample_out <= job_q.sample;
			end else if (!neg_res_q && quo_q[26:23] != 4'd0) begin
				sample_out <= 24'sh7F_FFFF;
			end else if (neg_res_q && quo_q[26:0] >= 27'd8388608) begin
				sample_out <= 24'sh80_0000;
			end else if (neg_res_q) begin
				sample_out <= 24'(-$signed(quo_q[26:0]));
			end else begin
				sample_out <= quo_q[23:0];
			end
		end
	end
endmodule
`default_nettype wire

@@ src/overload_clip_noise_cosine.sv @@
// Top level of the overload clip distortion block: config registers, front and back parts.
// Depends on ocn_pkg, ocn_front, ocn_back.
//
//  channel   handshake         payload
//  input     push / full       sample_in, channel
//  result    pop / empty       sample_out, clipped
//  config    cfg_valid/ready   cfg_index, cfg_data
//
// In the back part an item passes a take step, seven noise and cosine steps, a setup step,
// a 23-step ratio divider when unclipped (skipped when clipped or passed through), a sum
// step, a 27-step divider by the mode count and a hand-off.
// The hand-off stalls while the result register holds an unpopped result.
// The front queue holds two classified items; the result register holds one.
// Reset clears queues, state machine and per-channel state at once.
`timescale 1ns / 1ps
`default_nettype none
module overload_clip_noise_cosine #(
	parameter int unsigned CHANNELS = 2
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  signed [23:0]              sample_in,
	input  wire  [0:0]                      channel,
	output logic                            empty,
	input  wire                             pop,
	output logic signed [23:0]              sample_out,
	output logic                            clipped,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [2:0]                      cfg_index,
	input  wire  [31:0]                     cfg_data
);
	import ocn_pkg::*;

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [22:0] clip_level_q;
	logic [16:0] depth_q;
	logic [31:0] phase_inc_q;
	logic        noise_en_q, cos_en_q;
	logic [3:0]  mode_count_q;
	logic        job_valid, job_take;
	job_t        job;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_level_q <= 23'd4194304;
			depth_q      <= 17'd32768;
			phase_inc_q  <= 32'd42852282;
			noise_en_q   <= 1'b1;
			cos_en_q     <= 1'b0;
			mode_count_q <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLIP_LEVEL: clip_level_q <= cfg_data[22:0];
				REG_DEPTH:      depth_q      <= cfg_data[16:0];
				REG_PHASE_INC:  phase_inc_q  <= cfg_data;
				REG_NOISE_EN:   noise_en_q   <= cfg_data[0];
				REG_COSINE_EN:  cos_en_q     <= cfg_data[0];
				REG_MODE_COUNT: mode_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ocn_front #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_front (
		.clk, .arst_n, .push, .full, .sample_in, .channel,
		.clip_level(clip_level_q), .phase_increment(phase_inc_q),
		.noise_enable(noise_en_q), .cosine_enable(cos_en_q),
		.job_take, .job_valid, .job
	);

	ocn_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_take,
		.clip_level(clip_level_q), .depth(depth_q), .active_mode_count(mode_count_q),
		.empty, .pop, .sample_out, .clipped
	);

	// a job is never taken from an empty queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("job taken from empty queue");
	// full result register holds its value while not popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample_out))) else $error("result lost");
endmodule
`default_nettype wire
